[design/smshdr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smshdr_pkg
// shared types and constants for the sms read header field extractor
// ----------------------------------------------------------------------------
package smshdr_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned FIELD_W = 2;
	localparam int unsigned COUNT_W = 8;

	// per-field character limits (each 1..255)
	localparam logic [COUNT_W-1:0] TEL_MAX  = COUNT_W'(32);
	localparam logic [COUNT_W-1:0] TIME_MAX = COUNT_W'(32);
	localparam logic [COUNT_W-1:0] TEXT_MAX = COUNT_W'(160);

	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

	localparam logic [FIELD_W-1:0] FLD_TEL  = 2'd0;
	localparam logic [FIELD_W-1:0] FLD_TIME = 2'd1;
	localparam logic [FIELD_W-1:0] FLD_TEXT = 2'd2;

	typedef enum logic [2:0] {
		PH_SEEK_COMMA1,
		PH_SEEK_QUOTE1,
		PH_COPY_TEL,
		PH_SEEK_COMMA2,
		PH_SEEK_QUOTE2,
		PH_COPY_TIME,
		PH_SEEK_LF,
		PH_COPY_TEXT
	} phase_t;

	typedef struct packed {
		logic [FIELD_W-1:0] field;
		logic [CHAR_W-1:0]  chr;
		logic               char_valid;
		logic               done;
		logic               ok;
	} result_t;

endpackage

[design/smshdr_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smshdr_parser
// phase tracking and single-pass classification of one response byte
// ----------------------------------------------------------------------------
module smshdr_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         beat_take,
	input  logic [smshdr_pkg::CHAR_W-1:0] in_char,
	input  logic                         in_last,
	output logic                         res_present,
	output smshdr_pkg::result_t          res
);
	import smshdr_pkg::*;

	phase_t             phase_q, phase_next;
	logic [COUNT_W-1:0] count_q, count_next, count_inc;
	logic               finished_q;
	logic               emit, field_done, done;
	logic [FIELD_W-1:0] fld;

	assign count_inc = count_q + COUNT_W'(1);

	// next phase and field count
	always_comb begin
		phase_next = phase_q;
		count_next = count_q;
		case (phase_q)
			PH_SEEK_COMMA1: begin
				if (in_char == CH_COMMA) phase_next = PH_SEEK_QUOTE1;
			end
			PH_SEEK_QUOTE1: begin
				if (in_char == CH_QUOTE) begin
					phase_next = PH_COPY_TEL;
					count_next = '0;
				end
			end
			PH_COPY_TEL: begin
				if (in_char == CH_QUOTE) begin
					phase_next = PH_SEEK_COMMA2;
				end else begin
					count_next = count_inc;
					if (count_inc >= TEL_MAX) phase_next = PH_SEEK_COMMA2;
				end
			end
			PH_SEEK_COMMA2: begin
				if (in_char == CH_COMMA) phase_next = PH_SEEK_QUOTE2;
			end
			PH_SEEK_QUOTE2: begin
				if (in_char == CH_QUOTE) begin
					phase_next = PH_COPY_TIME;
					count_next = '0;
				end
			end
			PH_COPY_TIME: begin
				if (in_char == CH_QUOTE) begin
					phase_next = PH_SEEK_LF;
				end else begin
					count_next = count_inc;
					if (count_inc >= TIME_MAX) phase_next = PH_SEEK_LF;
				end
			end
			PH_SEEK_LF: begin
				if (in_char == CH_LF) begin
					phase_next = PH_COPY_TEXT;
					count_next = '0;
				end
			end
			PH_COPY_TEXT: begin
				if (in_char != CH_CR) count_next = count_inc;
			end
			default: begin
				phase_next = PH_SEEK_COMMA1;
			end
		endcase
	end

	// result for this byte
	always_comb begin
		emit       = 1'b0;
		field_done = 1'b0;
		fld        = FLD_TEL;
		case (phase_q)
			PH_COPY_TEL: begin
				emit = (in_char != CH_QUOTE);
				fld  = FLD_TEL;
			end
			PH_COPY_TIME: begin
				emit = (in_char != CH_QUOTE);
				fld  = FLD_TIME;
			end
			PH_COPY_TEXT: begin
				emit       = (in_char != CH_CR);
				fld        = FLD_TEXT;
				field_done = (in_char == CH_CR) || (count_inc >= TEXT_MAX);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign done = !finished_q && (field_done || in_last);

	assign res_present    = !finished_q && (emit || done);
	assign res.char_valid = !finished_q && emit;
	assign res.field      = (!finished_q && emit) ? fld : FLD_TEL;
	assign res.chr        = (!finished_q && emit) ? in_char : '0;
	assign res.done       = done;
	assign res.ok         = done && (field_done || (phase_next == PH_COPY_TEXT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEEK_COMMA1;
			count_q    <= '0;
			finished_q <= 1'b0;
		end else if (beat_take) begin
			if (in_last) begin
				phase_q    <= PH_SEEK_COMMA1;
				count_q    <= '0;
				finished_q <= 1'b0;
			end else if (!finished_q) begin
				phase_q    <= phase_next;
				count_q    <= count_next;
				finished_q <= done;
			end
		end
	end

endmodule

[design/smshdr_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smshdr_out_buf
// result register with a skid entry so input keeps flowing during a stall
// ----------------------------------------------------------------------------
module smshdr_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  smshdr_pkg::result_t push_res,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output smshdr_pkg::result_t out_res
);
	import smshdr_pkg::*;

	result_t main_q, skid_q;
	logic    main_valid_q, skid_valid_q;
	logic    pop;

	assign pop       = main_valid_q && out_ready;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;
	assign space     = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) skid_valid_q <= 1'b1;
			main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) main_q <= skid_q;
		end else if (push) begin
			if (main_valid_q && !pop) skid_q <= push_res;
			else main_q <= push_res;
		end
	end

endmodule

[design/sms_read_header_field_extractor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_read_header_field_extractor
// pulls phone number, timestamp and message text out of an sms read response
// ----------------------------------------------------------------------------
// usage
//  - input channel: one response byte per beat (in_char), in_last marks the
//    final byte of a response; valid/ready handshake
//  - output channel: one beat per extracted character and/or end of parse;
//    bytes that only move the scan along produce no output beat
//  - out_field tags the character (0 phone, 1 timestamp, 2 text); parse_done
//    with parse_ok reports success or a malformed header
//  - a result is registered in the output buffer; input takes one byte
//    per cycle while the buffer has space, set by the single phase update
//  - a stalled receiver is absorbed by a two-entry result buffer: input stays
//    ready until both entries are full, then resumes as the receiver drains
//  - reset (arst_n low) returns to seeking the first comma and empties the
//    buffer; the parse state also restarts after every in_last byte
// ----------------------------------------------------------------------------
module sms_read_header_field_extractor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [smshdr_pkg::CHAR_W-1:0]  in_char,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [smshdr_pkg::FIELD_W-1:0] out_field,
	output logic [smshdr_pkg::CHAR_W-1:0]  out_char,
	output logic                          char_valid,
	output logic                          parse_done,
	output logic                          parse_ok
);
	import smshdr_pkg::*;

	logic    beat_take;    // input beat accepted this cycle
	logic    res_present;  // this byte produces an output beat
	result_t res_now;
	result_t res_out;
	logic    buf_space;

	assign in_ready  = buf_space;
	assign beat_take = in_valid && buf_space;

	// byte classification and phase state
	smshdr_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat_take   (beat_take),
		.in_char     (in_char),
		.in_last     (in_last),
		.res_present (res_present),
		.res         (res_now)
	);

	// result register plus skid entry
	smshdr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (beat_take && res_present),
		.push_res  (res_now),
		.space     (buf_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res_out)
	);

	assign out_field  = res_out.field;
	assign out_char   = res_out.chr;
	assign char_valid = res_out.char_valid;
	assign parse_done = res_out.done;
	assign parse_ok   = res_out.ok;

endmodule

[test/sms_read_header_field_extractor_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_read_header_field_extractor_chk
// watches both channels of the extractor, predicts each result beat from the
// accepted input bytes and compares it field by field in arrival order
// ----------------------------------------------------------------------------
module sms_read_header_field_extractor_chk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [smshdr_pkg::CHAR_W-1:0]  in_char,
	input  logic                           in_last,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [smshdr_pkg::FIELD_W-1:0] out_field,
	input  logic [smshdr_pkg::CHAR_W-1:0]  out_char,
	input  logic                           char_valid,
	input  logic                           parse_done,
	input  logic                           parse_ok,
	output int                             errors,
	output int                             outstanding
);
	import smshdr_pkg::*;

	phase_t             scan_phase;
	logic [COUNT_W-1:0] field_len;
	logic               scan_finished;
	result_t            awaited_beats[$];

	initial errors = 0;
	assign outstanding = awaited_beats.size();

	// one byte through the scanner; returns 1 when the byte yields a result beat
	function automatic bit extract_step(input logic [CHAR_W-1:0] c, input logic last,
			output result_t r);
		logic               emit;
		logic               done;
		logic               ok;
		logic [FIELD_W-1:0] fld;
		emit = 1'b0;
		done = 1'b0;
		ok   = 1'b0;
		fld  = FLD_TEL;
		if (!scan_finished) begin
			case (scan_phase)
				PH_SEEK_COMMA1: if (c == CH_COMMA) scan_phase = PH_SEEK_QUOTE1;
				PH_SEEK_QUOTE1: if (c == CH_QUOTE) begin
					scan_phase = PH_COPY_TEL;
					field_len  = '0;
				end
				PH_COPY_TEL: if (c == CH_QUOTE) begin
					scan_phase = PH_SEEK_COMMA2;
				end else begin
					emit      = 1'b1;
					fld       = FLD_TEL;
					field_len = field_len + COUNT_W'(1);
					if (field_len >= TEL_MAX) scan_phase = PH_SEEK_COMMA2;
				end
				PH_SEEK_COMMA2: if (c == CH_COMMA) scan_phase = PH_SEEK_QUOTE2;
				PH_SEEK_QUOTE2: if (c == CH_QUOTE) begin
					scan_phase = PH_COPY_TIME;
					field_len  = '0;
				end
				PH_COPY_TIME: if (c == CH_QUOTE) begin
					scan_phase = PH_SEEK_LF;
				end else begin
					emit      = 1'b1;
					fld       = FLD_TIME;
					field_len = field_len + COUNT_W'(1);
					if (field_len >= TIME_MAX) scan_phase = PH_SEEK_LF;
				end
				PH_SEEK_LF: if (c == CH_LF) begin
					scan_phase = PH_COPY_TEXT;
					field_len  = '0;
				end
				PH_COPY_TEXT: if (c == CH_CR) begin
					done = 1'b1;
					ok   = 1'b1;
				end else begin
					emit      = 1'b1;
					fld       = FLD_TEXT;
					field_len = field_len + COUNT_W'(1);
					if (field_len >= TEXT_MAX) begin
						done = 1'b1;
						ok   = 1'b1;
					end
				end
				default: scan_phase = PH_SEEK_COMMA1;
			endcase
			if (!done && last) begin
				done = 1'b1;
				ok   = (scan_phase == PH_COPY_TEXT);
			end
			if (done) scan_finished = 1'b1;
		end
		if (last) begin
			scan_phase    = PH_SEEK_COMMA1;
			field_len     = '0;
			scan_finished = 1'b0;
		end
		r.field      = emit ? fld : '0;
		r.chr        = emit ? c : '0;
		r.char_valid = emit;
		r.done       = done;
		r.ok         = done && ok;
		return emit || done;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t r;
		result_t e;
		if (!arst_n) begin
			scan_phase    = PH_SEEK_COMMA1;
			field_len     = '0;
			scan_finished = 1'b0;
			awaited_beats.delete();
		end else begin
			if (in_valid && in_ready && extract_step(in_char, in_last, r))
				awaited_beats.push_back(r);
			if (out_valid && out_ready) begin
				if (awaited_beats.size() == 0) begin
					$error("unexpected result beat: field %0d char %02h valid %0b done %0b ok %0b",
						out_field, out_char, char_valid, parse_done, parse_ok);
					errors++;
				end else begin
					e = awaited_beats.pop_front();
					if (out_field !== e.field) begin
						$error("out_field: expected %0d, got %0d", e.field, out_field);
						errors++;
					end
					if (out_char !== e.chr) begin
						$error("out_char: expected %02h, got %02h", e.chr, out_char);
						errors++;
					end
					if (char_valid !== e.char_valid) begin
						$error("char_valid: expected %0b, got %0b", e.char_valid, char_valid);
						errors++;
					end
					if (parse_done !== e.done) begin
						$error("parse_done: expected %0b, got %0b", e.done, parse_done);
						errors++;
					end
					if (parse_ok !== e.ok) begin
						$error("parse_ok: expected %0b, got %0b", e.ok, parse_ok);
						errors++;
					end
				end
			end
		end
	end

endmodule

[test/sms_read_header_field_extractor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_read_header_field_extractor_tb
// drives whole sms read responses into the extractor - a few hand-built ones
// for the corner cases, then mostly well-formed responses with random content
// mixed with cut-short ones and plain noise - while the checker beside the
// block predicts and compares every result beat
// ----------------------------------------------------------------------------
module sms_read_header_field_extractor_tb;

	import smshdr_pkg::*;

	// rough number of input beats in the run, and where the quiet tail starts
	localparam int ITEMS      = 1950;
	localparam int QUIET_FROM = 1700;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic [CHAR_W-1:0]  in_char    = '0;
	logic               in_last    = 1'b0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic [FIELD_W-1:0] out_field;
	logic [CHAR_W-1:0]  out_char;
	logic               char_valid;
	logic               parse_done;
	logic               parse_ok;

	int                 errors;
	int                 outstanding;

	// idling switch shared by sender and receiver; cleared for the tail
	bit                 idle_en     = 1'b1;
	int                 stall_left  = 0;
	int                 beats_sent  = 0;
	logic [CHAR_W-1:0]  resp_bytes[$];

	sms_read_header_field_extractor u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_char    (in_char),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_field  (out_field),
		.out_char   (out_char),
		.char_valid (char_valid),
		.parse_done (parse_done),
		.parse_ok   (parse_ok)
	);

	sms_read_header_field_extractor_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_char     (in_char),
		.in_last     (in_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_field   (out_field),
		.out_char    (out_char),
		.char_valid  (char_valid),
		.parse_done  (parse_done),
		.parse_ok    (parse_ok),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: ready drops for random bursts while idling is allowed
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (idle_en && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_ready  <= 1'b0;
		end else begin
			out_ready  <= arst_n;
		end
	end

	// hard stop, several times the slowest legal run
	initial begin
		#10_000_000;
		$display("sms_read_header_field_extractor_tb: errors");
		$finish;
	end

	// one input beat; entered and left on a falling edge, valid held until taken
	task automatic send_beat(input logic [CHAR_W-1:0] c, input logic last);
		int gap;
		if (idle_en && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_char  <= c;
		in_last  <= last;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		beats_sent++;
	endtask

	// the whole response buffer, in_last on its final byte
	task automatic send_response();
		for (int i = 0; i < resp_bytes.size(); i++)
			send_beat(resp_bytes[i], i == resp_bytes.size() - 1);
	endtask

	// len random bytes, optionally never equal to a delimiter the scan looks for
	task automatic push_run(input int len, input logic [CHAR_W-1:0] banned, input bit ban);
		logic [CHAR_W-1:0] c;
		for (int i = 0; i < len; i++) begin
			do c = CHAR_W'($urandom_range(0, 255)); while (ban && c == banned);
			resp_bytes.push_back(c);
		end
	endtask

	// field length: mostly short, now and then straddling the limit
	function automatic int field_len(input int limit, input int short_max);
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(limit - 3, limit + 6);
		return $urandom_range(0, short_max);
	endfunction

	// one response: well-formed with random content, cut short, or pure noise
	task automatic build_response();
		int keep;
		resp_bytes.delete();
		if ($urandom_range(0, 9) == 0) begin
			push_run($urandom_range(1, 24), '0, 1'b0);
		end else begin
			// header up to the phone number
			push_run($urandom_range(0, 6), CH_COMMA, 1'b1);
			resp_bytes.push_back(CH_COMMA);
			push_run($urandom_range(0, 3), CH_QUOTE, 1'b1);
			resp_bytes.push_back(CH_QUOTE);
			push_run(field_len(TEL_MAX, 14), CH_QUOTE, 1'b1);
			resp_bytes.push_back(CH_QUOTE);
			// on to the timestamp
			push_run($urandom_range(0, 3), CH_COMMA, 1'b1);
			resp_bytes.push_back(CH_COMMA);
			push_run($urandom_range(0, 3), CH_QUOTE, 1'b1);
			resp_bytes.push_back(CH_QUOTE);
			push_run(field_len(TIME_MAX, 12), CH_QUOTE, 1'b1);
			resp_bytes.push_back(CH_QUOTE);
			// rest of the header line, then the text
			push_run($urandom_range(0, 5), CH_LF, 1'b1);
			resp_bytes.push_back(CH_LF);
			push_run(field_len(TEXT_MAX, 20), CH_CR, 1'b1);
			// some end with the text still open
			if ($urandom_range(0, 4) != 0) begin
				resp_bytes.push_back(CH_CR);
				push_run($urandom_range(0, 3), '0, 1'b0);
			end
			// a quarter get cut off somewhere
			if ($urandom_range(0, 3) == 0) begin
				keep = $urandom_range(1, resp_bytes.size());
				while (resp_bytes.size() > keep) void'(resp_bytes.pop_back());
			end
		end
	endtask

	initial begin
		bit paused;
		paused = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// lone last byte while still hunting for the first comma: malformed
		resp_bytes = '{8'hFF};
		send_response();
		// minimal response with zero and all-ones characters, closed by a
		// carriage return, then a byte that is ignored and carries the last mark
		resp_bytes = '{CH_COMMA, CH_QUOTE, 8'h00, CH_QUOTE, CH_COMMA, CH_QUOTE,
			8'hFF, CH_QUOTE, CH_LF, 8'h80, CH_CR, 8'h7F};
		send_response();
		// empty phone and timestamp, input ends on the line feed: text reached
		resp_bytes = '{CH_COMMA, CH_QUOTE, CH_QUOTE, CH_COMMA, CH_QUOTE, CH_QUOTE, CH_LF};
		send_response();

		while (beats_sent < ITEMS) begin
			if (beats_sent >= QUIET_FROM) idle_en = 1'b0;
			// once, mid-run, hold the sender off until every result is out
			if (!paused && beats_sent >= ITEMS / 2) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				@(negedge clk);
				while (outstanding != 0) @(negedge clk);
			end
			build_response();
			send_response();
		end

		// drain, then wait on for anything stray to show up
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		if (errors == 0 && outstanding == 0)
			$display("sms_read_header_field_extractor_tb: clean");
		else
			$display("sms_read_header_field_extractor_tb: errors");
		$finish;
	end

endmodule
